### hdl/dteq_pkg.sv
// Package for the delta timer event queue: operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package dteq_pkg;

   localparam int STAMP_W = 32;

   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_ADVANCE  = 2'd1;
   localparam logic [1:0] OP_CANCEL   = 2'd2;

   localparam logic [2:0] ST_SCHEDULED   = 3'd0;
   localparam logic [2:0] ST_CANCELLED   = 3'd1;
   localparam logic [2:0] ST_NOT_PENDING = 3'd2;
   localparam logic [2:0] ST_EXPIRED     = 3'd3;
   localparam logic [2:0] ST_NONE        = 3'd4;

   typedef struct packed {
      logic sched;      // schedule with the request fields
      logic cancel;     // cancel with the request fields
      logic adv_start;  // capture steps and clear the winner tracker
      logic scan;       // age or mark the indexed slot
      logic search;     // compare the indexed slot if it is due
      logic emit_best;  // emit the winner, including the indexed slot
      logic emit_none;  // emit a nothing-expired result
   } dteq_cmd_type;

   typedef struct packed {
      logic any_due;    // at least one expiry in this advance so far
      logic more_due;   // expiries remain after the one emitted now
   } dteq_stat_type;

endpackage

### hdl/dteq_ctrl.sv
// Controller of the delta timer event queue: state machine and slot index.
// Depends on dteq_pkg.
module dteq_ctrl
   import dteq_pkg::*;
#(
   parameter int EVENT_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     req_opcode,
   output logic                           busy,
   output dteq_cmd_type                   cmd,
   output logic [$clog2(EVENT_SLOTS)-1:0] idx,
   input  dteq_stat_type                  stat
);

   localparam int SW = $clog2(EVENT_SLOTS);
   localparam logic [SW-1:0] LAST_IDX = SW'(EVENT_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_SEARCH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] idx_ff, idx_in;

   assign busy = (state_ff != S_IDLE);
   assign idx  = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.sched     = (req_opcode == OP_SCHEDULE);
               cmd.cancel    = (req_opcode == OP_CANCEL);
               cmd.adv_start = (req_opcode == OP_ADVANCE);
               if (req_opcode == OP_ADVANCE) begin
                  state_in = S_SCAN;
                  idx_in   = '0;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == LAST_IDX) begin
               cmd.emit_best = stat.any_due;
               cmd.emit_none = !stat.any_due;
               idx_in        = '0;
               state_in      = (stat.any_due && stat.more_due) ? S_SEARCH : S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (idx_ff == LAST_IDX) begin
               cmd.emit_best = 1'b1;
               idx_in        = '0;
               state_in      = stat.more_due ? S_SEARCH : S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // An expiry or nothing-expired result is only ever emitted on the final slot of a pass.
   a_emit_at_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_best || cmd.emit_none) |-> (idx_ff == LAST_IDX))
      else $error("emit away from the end of a pass");

   a_busy_after_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.adv_start |=> (busy && idx_ff == '0))
      else $error("advance did not start a scan");

   a_none_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_none |-> (state_ff == S_SCAN))
      else $error("nothing-expired result outside the scan pass");

endmodule

### hdl/dteq_datapath.sv
// Datapath of the delta timer event queue: slot table, due marks, the
// earliest-expiry tracker and the result registers. Depends on dteq_pkg.
module dteq_datapath
   import dteq_pkg::*;
#(
   parameter int EVENT_SLOTS = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dteq_cmd_type                   cmd,
   input  logic [$clog2(EVENT_SLOTS)-1:0] idx,
   output dteq_stat_type                  stat,
   input  logic [3:0]                     req_tag,
   input  logic [31:0]                    req_delay,
   input  logic [31:0]                    req_steps,
   output logic                           rsp_strobe,
   output logic [2:0]                     rsp_status,
   output logic [3:0]                     rsp_expired_tag,
   output logic [4:0]                     rsp_pending_count,
   output logic                           rsp_last
);

   localparam int SW    = $clog2(EVENT_SLOTS);
   localparam int CW    = $clog2(EVENT_SLOTS + 1);
   localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic [TIME_BITS-1:0] rem_ff   [EVENT_SLOTS];
   logic [STAMP_W-1:0]   stamp_ff [EVENT_SLOTS];
   logic [EVENT_SLOTS-1:0] pend_ff, due_ff;
   logic [STAMP_W-1:0]   seq_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        ndue_ff, ndue_in;
   logic [31:0]          steps_ff;
   logic                 best_ok_ff, win_ok;
   logic [SW-1:0]        best_idx_ff, win_idx;
   logic [TIME_BITS-1:0] best_when_ff, win_when;
   logic [STAMP_W-1:0]   best_stamp_ff, win_stamp;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_tag_ff, rsp_tag_in;
   logic [4:0]           rsp_count_ff;
   logic                 rsp_last_ff;

   logic [TIME_BITS-1:0] cur_rem, aged_rem;
   logic [STAMP_W-1:0]   cur_stamp;
   logic                 cur_pend, in_reach, is_due, better;
   logic [SW-1:0]        slot;
   logic                 tag_ok, slot_pend;

   assign slot      = SW'(req_tag);
   assign tag_ok    = (int'(req_tag) < EVENT_SLOTS);
   assign slot_pend = tag_ok && pend_ff[slot];

   always_comb begin
      cur_rem   = rem_ff[idx];
      cur_stamp = stamp_ff[idx];
      cur_pend  = pend_ff[idx];
      in_reach  = (CMP_W'(cur_rem) <= CMP_W'(steps_ff));
      aged_rem  = cur_rem - TIME_BITS'(steps_ff);
      is_due    = (cmd.scan && cur_pend && in_reach) || (cmd.search && due_ff[idx]);
      better    = !best_ok_ff || (cur_rem < best_when_ff) ||
                  ((cur_rem == best_when_ff) && (cur_stamp > best_stamp_ff));
      win_ok    = best_ok_ff || is_due;
      if (is_due && better) begin
         win_idx   = idx;
         win_when  = cur_rem;
         win_stamp = cur_stamp;
      end else begin
         win_idx   = best_idx_ff;
         win_when  = best_when_ff;
         win_stamp = best_stamp_ff;
      end

      // Expired slots leave the pending count as soon as the scan finds them.
      cnt_in = cnt_ff;
      if (cmd.sched && tag_ok && !pend_ff[slot]) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.cancel && slot_pend) begin
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.scan && is_due) begin
         cnt_in = cnt_ff - 1'b1;
      end

      ndue_in = ndue_ff + CW'(cmd.scan && is_due);
      stat.any_due  = (ndue_in != '0);
      stat.more_due = (ndue_in > CW'(1));

      rsp_status_in = ST_NONE;
      rsp_tag_in    = req_tag;
      if (cmd.sched) begin
         rsp_status_in = tag_ok ? ST_SCHEDULED : ST_NOT_PENDING;
      end else if (cmd.cancel) begin
         rsp_status_in = slot_pend ? ST_CANCELLED : ST_NOT_PENDING;
      end else if (cmd.emit_best) begin
         rsp_status_in = ST_EXPIRED;
         rsp_tag_in    = 4'(win_idx);
      end else begin
         rsp_tag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sched && tag_ok) begin
         rem_ff[slot]   <= TIME_BITS'(req_delay);
         stamp_ff[slot] <= seq_ff;
      end
      if (cmd.scan && cur_pend && !in_reach) begin
         rem_ff[idx] <= aged_rem;
      end
      if (cmd.adv_start) begin
         steps_ff <= req_steps;
      end
      best_idx_ff   <= win_idx;
      best_when_ff  <= win_when;
      best_stamp_ff <= win_stamp;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= 5'(cnt_in);
      rsp_last_ff   <= cmd.emit_best ? !stat.more_due : 1'b1;

      if (reset) begin
         pend_ff      <= '0;
         due_ff       <= '0;
         seq_ff       <= '0;
         cnt_ff       <= '0;
         ndue_ff      <= '0;
         best_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.sched || cmd.cancel || cmd.emit_best || cmd.emit_none;
         if (cmd.sched && tag_ok) begin
            pend_ff[slot] <= 1'b1;
            seq_ff        <= seq_ff + 1'b1;
         end
         if (cmd.cancel && slot_pend) begin
            pend_ff[slot] <= 1'b0;
         end
         if (cmd.scan && is_due) begin
            pend_ff[idx] <= 1'b0;
            due_ff[idx]  <= 1'b1;
         end
         if (cmd.adv_start) begin
            best_ok_ff <= 1'b0;
            ndue_ff    <= '0;
         end else if (cmd.emit_best || cmd.emit_none) begin
            best_ok_ff       <= 1'b0;
            ndue_ff          <= cmd.emit_best ? ndue_in - 1'b1 : '0;
            due_ff[win_idx]  <= 1'b0;
         end else begin
            best_ok_ff <= win_ok;
            ndue_ff    <= ndue_in;
         end
      end
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_tag   = rsp_tag_ff;
   assign rsp_pending_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(pend_ff) == int'(cnt_ff))
      else $error("pending count out of step with the pending flags");

   a_due_not_pending: assert property (@(posedge clock) disable iff (reset)
      (due_ff & pend_ff) == '0)
      else $error("slot both due and pending");

   a_due_count: assert property (@(posedge clock) disable iff (reset)
      $countones(due_ff) == int'(ndue_ff))
      else $error("due count out of step with the due marks");

endmodule

### hdl/delta_timer_event_queue.sv
// Top level of the delta timer event queue: controller and datapath.
// Depends on dteq_pkg, dteq_ctrl and dteq_datapath.
//
// A command is taken at a rising edge with start high and busy low. Opcode
// schedule makes a tag pending with req_delay ticks to go (replacing any old
// time); cancel drops a pending tag; advance moves time by req_steps ticks.
// Schedule and cancel answer with one result in the next cycle and
// leave busy low, so a command can follow in every cycle. An advance scans
// one slot per cycle through a single compare unit: the first result is
// emitted at the end of the scan pass, and each further expiry takes
// another search pass; busy stays high through all of these passes.
// Expired events come out earliest first, the later schedule first among
// equal times, with rsp_last on the final one; an advance that expires
// nothing gives one nothing-expired result. Each result stands on the
// rsp_ ports for one cycle, marked by rsp_strobe; the receiver cannot stall
// it. Reset clears all pending events and the schedule order stamp; the
// block is ready in the first cycle after reset.
module delta_timer_event_queue
   import dteq_pkg::*;
#(
   parameter int EVENT_SLOTS = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_tag,
   input  logic [31:0] req_delay,
   input  logic [31:0] req_steps,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_expired_tag,
   output logic [4:0]  rsp_pending_count,
   output logic        rsp_last
);

   dteq_cmd_type                   cmd;
   dteq_stat_type                  stat;
   logic [$clog2(EVENT_SLOTS)-1:0] idx;

   dteq_ctrl #(
      .EVENT_SLOTS (EVENT_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd),
      .idx        (idx),
      .stat       (stat)
   );

   dteq_datapath #(
      .EVENT_SLOTS (EVENT_SLOTS),
      .TIME_BITS   (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .idx               (idx),
      .stat              (stat),
      .req_tag           (req_tag),
      .req_delay         (req_delay),
      .req_steps         (req_steps),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_expired_tag   (rsp_expired_tag),
      .rsp_pending_count (rsp_pending_count),
      .rsp_last          (rsp_last)
   );

endmodule
